// ----- src/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants and codes for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VALUE_W   = 32;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int MATCH_W   = 7;
	localparam int OCC_W     = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK   = 2'd0,
		OP_PUSH_FRONT  = 2'd1,
		OP_REMOVE_BACK = 2'd2,
		OP_SEARCH      = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	localparam logic signed [MATCH_W-1:0] NO_MATCH = '1;

endpackage

// ----- src/bdq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_req_if / bdq_rsp_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	import bdq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [VALUE_W-1:0] item_value;

	modport source (output valid, output operation, output item_value, input ready);
	modport sink (input valid, input operation, input item_value, output ready);
endinterface

interface bdq_rsp_if;
	import bdq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [MATCH_W-1:0] match_position;
	logic [OCC_W-1:0]          occupancy;

	modport source (output valid, output status, output match_position, output occupancy,
		input ready);
	modport sink (input valid, input status, input match_position, input occupancy,
		output ready);
endinterface

// ----- src/bdq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_store #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [PTR_W-1:0]           wr_addr,
	input  logic [bdq_pkg::VALUE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [PTR_W-1:0]           rd_addr,
	output logic [bdq_pkg::VALUE_W-1:0] rd_data
);
	import bdq_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/bdq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Ring pointers, operation sequencer, search scan and result register.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bdq_req_if.sink                     req,
	bdq_rsp_if.source                   rsp,
	output logic                        wr_en,
	output logic [PTR_W-1:0]            wr_addr,
	output logic [bdq_pkg::VALUE_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [PTR_W-1:0]            rd_addr,
	input  logic [bdq_pkg::VALUE_W-1:0] rd_data
);
	import bdq_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int IEXT_W = (PTR_W > MATCH_W) ? PTR_W : MATCH_W;
	localparam int CEXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		ptr_dec = (p == '0) ? LAST_PTR : p - PTR_W'(1);
	endfunction

	state_t                    state_q, state_d;
	logic [PTR_W-1:0]          fp_q, fp_d;
	logic [CNT_W-1:0]          cnt_q, cnt_d;
	logic [VALUE_W-1:0]        key_q, key_d;
	logic [PTR_W-1:0]          scan_ptr_q, scan_ptr_d;
	logic [PTR_W-1:0]          cmp_i_s1, cmp_i_d;
	logic signed [MATCH_W-1:0] match_q, match_d;
	logic                      rsp_valid_q, rsp_valid_d;
	status_t                   rsp_status_q, rsp_status_d;
	logic signed [MATCH_W-1:0] rsp_match_q, rsp_match_d;
	logic [OCC_W-1:0]          rsp_occ_q, rsp_occ_d;

	logic              out_free;
	logic              accept;
	logic              req_ready;
	logic              load;
	logic              full;
	logic              empty;
	logic              hit;
	logic              last;
	logic [SUM_W-1:0]  sum_back;
	logic [SUM_W-1:0]  sum_tail;
	logic [PTR_W-1:0]  back_idx;
	logic [PTR_W-1:0]  tail_idx;
	logic [PTR_W-1:0]  front_dec;
	logic [IEXT_W-1:0] i_ext;
	logic [CEXT_W-1:0] occ_ext;
	op_t               op;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req_ready;
	assign op        = op_t'(req.operation);
	assign full      = (cnt_q == FULL_CNT);
	assign empty     = (cnt_q == '0);
	assign sum_back  = SUM_W'(fp_q) + SUM_W'(cnt_q) - SUM_W'(1);
	assign sum_tail  = SUM_W'(fp_q) + SUM_W'(cnt_q);
	assign back_idx  = (sum_back >= DEPTH_S) ? PTR_W'(sum_back - DEPTH_S) : PTR_W'(sum_back);
	assign tail_idx  = (sum_tail >= DEPTH_S) ? PTR_W'(sum_tail - DEPTH_S) : PTR_W'(sum_tail);
	assign front_dec = ptr_dec(fp_q);
	assign hit       = (rd_data == key_q);
	assign last      = ((CNT_W'(cmp_i_s1) + CNT_W'(1)) == cnt_q);
	assign i_ext     = IEXT_W'(cmp_i_s1);

	always_comb begin
		state_d      = state_q;
		fp_d         = fp_q;
		cnt_d        = cnt_q;
		key_d        = key_q;
		scan_ptr_d   = scan_ptr_q;
		cmp_i_d      = cmp_i_s1;
		match_d      = match_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		rsp_status_d = rsp_status_q;
		rsp_match_d  = rsp_match_q;
		rsp_occ_d    = rsp_occ_q;
		load         = 1'b0;
		req_ready    = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = tail_idx;
		wr_data      = VALUE_W'(req.item_value);
		rd_en        = 1'b0;
		rd_addr      = back_idx;

		case (state_q)
			S_IDLE: begin
				req_ready = out_free;
				if (accept) begin
					rsp_status_d = ST_DONE;
					rsp_match_d  = NO_MATCH;
					case (op)
						OP_PUSH_BACK: begin
							load = 1'b1;
							if (full) begin
								rsp_status_d = ST_FULL;
							end else begin
								wr_en = 1'b1;
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						OP_PUSH_FRONT: begin
							load = 1'b1;
							if (full) begin
								rsp_status_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = front_dec;
								fp_d    = front_dec;
								cnt_d   = cnt_q + CNT_W'(1);
							end
						end
						OP_REMOVE_BACK: begin
							load = 1'b1;
							if (empty) begin
								rsp_status_d = ST_EMPTY;
							end else begin
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						OP_SEARCH: begin
							if (empty) begin
								load = 1'b1;
							end else begin
								rd_en      = 1'b1;
								key_d      = VALUE_W'(req.item_value);
								scan_ptr_d = ptr_dec(back_idx);
								cmp_i_d    = '0;
								state_d    = S_SCAN;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					match_d = i_ext[MATCH_W-1:0];
					state_d = S_HOLD;
				end else if (last) begin
					match_d = NO_MATCH;
					state_d = S_HOLD;
				end else begin
					rd_en      = 1'b1;
					rd_addr    = scan_ptr_q;
					scan_ptr_d = ptr_dec(scan_ptr_q);
					cmp_i_d    = cmp_i_s1 + PTR_W'(1);
				end
			end
			S_HOLD: begin
				if (out_free) begin
					load         = 1'b1;
					rsp_status_d = ST_DONE;
					rsp_match_d  = match_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		occ_ext = CEXT_W'(cnt_d);
		if (load) begin
			rsp_valid_d = 1'b1;
			rsp_occ_d   = occ_ext[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fp_q        <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fp_q        <= fp_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q        <= key_d;
		scan_ptr_q   <= scan_ptr_d;
		cmp_i_s1     <= cmp_i_d;
		match_q      <= match_d;
		rsp_status_q <= rsp_status_d;
		rsp_match_q  <= rsp_match_d;
		rsp_occ_q    <= rsp_occ_d;
	end

	assign req.ready          = req_ready;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.match_position = rsp_match_q;
	assign rsp.occupancy      = rsp_occ_q;

endmodule

// ----- src/bounded_deque_with_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit values held in a ring memory,
// with push back, push front, remove back and search from the back.
//
//   channel  dir  payload                                   handshake
//   req      in   operation, item_value                     valid / ready
//   rsp      out  status, match_position, occupancy         valid / ready
//
// Push and remove: result is registered in the cycle after the item is taken.
// Search: the single memory read port walks one entry per cycle from the back
// until a match or the last entry is seen; S_HOLD then loads the result.
// One item is in work at a time; a new item is taken only when the result
// slot is empty or its result is taken in the same cycle.
// Reset clears the front pointer and count; memory contents are not cleared.
// A stalled result holds off the request channel until taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);
	import bdq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	logic               wr_en;
	logic [PTR_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               rd_en;
	logic [PTR_W-1:0]   rd_addr;
	logic [VALUE_W-1:0] rd_data;

	bdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bdq_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("memory read and write in the same cycle");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.operation != OP_SEARCH) |=> rsp.valid)
		else $error("push or remove item gave no result in the next cycle");

	a_ready_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!rsp.valid || rsp.ready))
		else $error("item taken while result slot is blocked");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en |-> (int'(wr_addr) < DEPTH)) and (rd_en |-> (int'(rd_addr) < DEPTH)))
		else $error("memory address beyond depth");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded deque with search. Drives push, remove
// and search items through the request channel with random gaps, stalls the
// result channel at random, and compares every result against an in-bench
// deque that tracks the ring store, the head pointer and the entry count.
// ----------------------------------------------------------------------------
module tb;
	import bdq_pkg::*;

	localparam int DEPTH     = DEPTH_DEF;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int WDOG_MAX  = 2000;
	localparam int DRAIN_CYC = DEPTH + 4;

	typedef struct {
		op_t                       op;
		status_t                   status;
		logic signed [MATCH_W-1:0] match_position;
		logic [OCC_W-1:0]          occupancy;
	} deque_result_t;

	logic clk;
	logic arst_n;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic signed [VALUE_W-1:0] deque_store [DEPTH];
	logic [PTR_W-1:0]          deque_head;
	logic [OCC_W-1:0]          deque_count;
	logic signed [VALUE_W-1:0] value_pool [8];

	deque_result_t pending_results [$];
	deque_result_t want;
	int            failures;
	int            stall_left;
	int            ready_roll;
	int            idle_cycles;
	bit            quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic deque_result_t deque_apply(op_t op, logic signed [VALUE_W-1:0] v);
		deque_result_t    res;
		logic [PTR_W-1:0] idx;
		bit               found;
		int               i;
		res.op             = op;
		res.status         = ST_DONE;
		res.match_position = NO_MATCH;
		found              = 1'b0;
		case (op)
			OP_PUSH_BACK: begin
				if (deque_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					idx              = deque_head + deque_count[PTR_W-1:0];
					deque_store[idx] = v;
					deque_count      = deque_count + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (deque_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					deque_head              = deque_head - 1'b1;
					deque_store[deque_head] = v;
					deque_count             = deque_count + 1'b1;
				end
			end
			OP_REMOVE_BACK: begin
				if (deque_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					deque_count = deque_count - 1'b1;
				end
			end
			default: begin
				for (i = 0; i < deque_count && !found; i++) begin
					idx = deque_head + deque_count[PTR_W-1:0] - 1'b1 - PTR_W'(i);
					if (deque_store[idx] == v) begin
						found              = 1'b1;
						res.match_position = MATCH_W'(i);
					end
				end
			end
		endcase
		res.occupancy = deque_count;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return value_pool[$urandom_range(0, 7)];
		if (r < 38) return 32'sh8000_0000;
		if (r < 41) return 32'sh7FFF_FFFF;
		if (r < 43) return '0;
		if (r < 45) return '1;
		return $urandom;
	endfunction

	task automatic send_item(op_t op, logic signed [VALUE_W-1:0] v);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.item_value <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.push_back(deque_apply(op, v));
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic note_failure(string msg);
		failures++;
		if (failures <= 10) $display("%s", msg);
	endtask

	task automatic test_empty_queue();
		send_item(OP_REMOVE_BACK, 32'sh1234_5678);
		send_item(OP_SEARCH, '0);
		send_item(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_item(OP_SEARCH, 32'sh7FFF_FFFF);
		send_item(OP_REMOVE_BACK, '0);
		send_item(OP_REMOVE_BACK, '1);
		send_item(OP_SEARCH, 32'sh7FFF_FFFF);
	endtask

	task automatic test_value_extremes();
		send_item(OP_PUSH_BACK, 32'sh8000_0000);
		send_item(OP_PUSH_BACK, 32'sh7FFF_FFFF);
		send_item(OP_PUSH_FRONT, '0);
		send_item(OP_PUSH_FRONT, '1);
		send_item(OP_PUSH_BACK, 32'sh5555_5555);
		send_item(OP_PUSH_BACK, 32'shAAAA_AAAA);
		send_item(OP_PUSH_FRONT, 32'sh8000_0000);
		send_item(OP_SEARCH, 32'sh8000_0000);
		send_item(OP_SEARCH, '1);
		send_item(OP_SEARCH, '0);
		send_item(OP_SEARCH, 32'sh0000_3039);
		send_item(OP_REMOVE_BACK, '0);
		send_item(OP_SEARCH, 32'shAAAA_AAAA);
		send_item(OP_REMOVE_BACK, '0);
		send_item(OP_REMOVE_BACK, '0);
		send_item(OP_SEARCH, 32'sh7FFF_FFFF);
	endtask

	task automatic test_full_queue();
		logic signed [VALUE_W-1:0] v;
		hold_until_drained();
		quiet = 1'b1;
		while (deque_count < DEPTH) begin
			v = $urandom | 32'h1;
			send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, v);
			if (deque_count == DEPTH / 2) quiet = 1'b0;
		end
		send_item(OP_PUSH_BACK, 32'sh0BAD_0001);
		send_item(OP_PUSH_FRONT, 32'sh0BAD_0003);
		send_item(OP_SEARCH, deque_store[deque_head]);
		send_item(OP_SEARCH, 32'sh2468_ACE0);
		while (deque_count != 0) send_item(OP_REMOVE_BACK, $urandom);
		send_item(OP_REMOVE_BACK, $urandom);
		hold_until_drained();
	endtask

	task automatic test_random_mix(int n);
		logic signed [VALUE_W-1:0] v;
		logic [PTR_W-1:0]          pick;
		op_t                       op;
		int                        k;
		int                        r;
		int                        phase;
		int                        phase_left;
		for (k = 0; k < 8; k++) value_pool[k] = (k < 4) ? VALUE_W'(k) : $urandom;
		phase_left = 0;
		phase      = 0;
		for (k = 0; k < n; k++) begin
			if (phase_left == 0) begin
				phase      = $urandom_range(0, 2);
				phase_left = $urandom_range(30, 90);
				quiet      = ($urandom_range(0, 5) == 0);
			end
			phase_left--;
			r = $urandom_range(0, 99);
			case (phase)
				0: op = (r < 40) ? OP_PUSH_BACK : (r < 75) ? OP_PUSH_FRONT :
					(r < 85) ? OP_REMOVE_BACK : OP_SEARCH;
				1: op = (r < 10) ? OP_PUSH_BACK : (r < 20) ? OP_PUSH_FRONT :
					(r < 80) ? OP_REMOVE_BACK : OP_SEARCH;
				default: op = (r < 20) ? OP_PUSH_BACK : (r < 35) ? OP_PUSH_FRONT :
					(r < 60) ? OP_REMOVE_BACK : OP_SEARCH;
			endcase
			if (op == OP_SEARCH && deque_count != 0 && $urandom_range(0, 99) < 55) begin
				pick = deque_head + PTR_W'($urandom_range(0, deque_count - 1));
				v    = deque_store[pick];
			end else begin
				v = pick_value();
			end
			send_item(op, v);
			if (k % 200 == 199) hold_until_drained();
		end
		quiet = 1'b0;
	endtask

	always @(negedge clk) begin
		if (!quiet && stall_left == 0) begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 3) stall_left = $urandom_range(8, 40);
			else if (ready_roll < 15) stall_left = $urandom_range(1, 3);
		end
		if (!quiet && stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: status %0d match %0d occupancy %0d",
					rsp_ch.status, rsp_ch.match_position, rsp_ch.occupancy));
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status ||
						rsp_ch.match_position !== want.match_position ||
						rsp_ch.occupancy !== want.occupancy) begin
					note_failure($sformatf({"%s mismatch: status %0d/%0d match %0d/%0d ",
						"occupancy %0d/%0d (expected/actual)"}, want.op.name(),
						want.status, rsp_ch.status, want.match_position,
						rsp_ch.match_position, want.occupancy, rsp_ch.occupancy));
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WDOG_MAX) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[bounded_deque_with_search] ERROR");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_PUSH_BACK;
		req_ch.item_value = '0;
		rsp_ch.ready      = 1'b0;
		deque_head        = '0;
		deque_count       = '0;
		failures          = 0;
		stall_left        = 0;
		quiet             = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_empty_queue();
		test_value_extremes();
		test_full_queue();
		test_random_mix(760);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (failures == 0) begin
			$display("[bounded_deque_with_search] OK");
		end else begin
			$display("[bounded_deque_with_search] ERROR");
		end
		$finish;
	end

endmodule
